// File: hw/rtl/cmf4_pkg.sv
// Shared types and constants for the cmap format 4 glyph lookup block.
// No dependencies; the ALU, register file, top level and bench refer to this package by scoped names.
package cmf4_pkg;

  // Default sizes of the segment table and the glyph array
  localparam int MAX_SEGMENTS_DEF    = 256;
  localparam int MAX_GLYPH_WORDS_DEF = 4096;

  // Item kinds
  localparam logic [1:0] KIND_SEG    = 2'd0;
  localparam logic [1:0] KIND_GLYPH  = 2'd1;
  localparam logic [1:0] KIND_LOOKUP = 2'd2;

  // Register indexes and address width (registers at 4 * index)
  localparam logic REG_SEGS   = 1'b0;
  localparam logic REG_GLYPHS = 1'b1;
  localparam int   CFG_AW     = 3;

  localparam int SEGS_W   = 9;
  localparam int GLYPHS_W = 13;

  // Shared adder lane width: operands stay below 2**17, bit 17 is the borrow
  localparam int ALU_W = 18;

  localparam logic ALU_ADD = 1'b0;
  localparam logic ALU_SUB = 1'b1;

  typedef struct packed {
    logic [SEGS_W-1:0]   segs;
    logic [GLYPHS_W-1:0] glyphs;
  } cfg_t;

  typedef struct packed {
    logic [15:0] first;
    logic [15:0] last;
    logic [15:0] delta;
    logic [15:0] offset;
  } seg_entry_t;

  typedef struct packed {
    logic             op0;
    logic [ALU_W-1:0] a0;
    logic [ALU_W-1:0] b0;
    logic             op1;
    logic [ALU_W-1:0] a1;
    logic [ALU_W-1:0] b1;
  } alu_req_t;

  typedef struct packed {
    logic [ALU_W-1:0] r0;
    logic [ALU_W-1:0] r1;
  } alu_rsp_t;

endpackage

// File: hw/rtl/cmf4_channels.sv
// Valid/ready channel interfaces for lookup requests and lookup results.
// No dependencies.
interface cmf4_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [11:0]        entry_index;
  logic [15:0]        range_first;
  logic [15:0]        range_last;
  logic signed [15:0] glyph_delta;
  logic [15:0]        array_offset;
  logic [15:0]        glyph_word;
  logic [15:0]        char_code;

  modport source (output valid, kind, entry_index, range_first, range_last, glyph_delta,
                  array_offset, glyph_word, char_code, input ready);
  modport sink   (input valid, kind, entry_index, range_first, range_last, glyph_delta,
                  array_offset, glyph_word, char_code, output ready);
endinterface

interface cmf4_rsp_if;
  logic        valid;
  logic        ready;
  logic        mapped;
  logic [15:0] glyph_index;

  modport source (output valid, mapped, glyph_index, input ready);
  modport sink   (input valid, mapped, glyph_index, output ready);
endinterface

// File: hw/rtl/cmf4_ram.sv
// Single write port, single registered read port memory.
// Used for the segment table and the glyph array; no dependencies.
module cmf4_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/cmf4_alu.sv
// Shared two-lane add/subtract unit driven by the lookup sequencer.
// Depends on cmf4_pkg for the request and result structs.
module cmf4_alu (
  input  cmf4_pkg::alu_req_t req,
  output cmf4_pkg::alu_rsp_t rsp
);

  // Each lane adds or subtracts; on subtract the top bit flags a borrow
  always_comb begin
    rsp.r0 = (req.op0 == cmf4_pkg::ALU_SUB) ? req.a0 - req.b0 : req.a0 + req.b0;
    rsp.r1 = (req.op1 == cmf4_pkg::ALU_SUB) ? req.a1 - req.b1 : req.a1 + req.b1;
  end

endmodule

// File: hw/rtl/cmf4_cfg.sv
// APB-style register file: segment count and glyph word count.
// Depends on cmf4_pkg for register indexes and the cfg_t struct.
module cmf4_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cmf4_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output cmf4_pkg::cfg_t              cfg
);

  logic [cmf4_pkg::SEGS_W-1:0]   segs;
  logic [cmf4_pkg::GLYPHS_W-1:0] glyphs;
  logic                          reg_index;

  assign pready    = 1'b1;
  assign reg_index = paddr[2];

  // Write on the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      segs   <= '0;
      glyphs <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (reg_index)
        cmf4_pkg::REG_SEGS:   segs   <= pwdata[cmf4_pkg::SEGS_W-1:0];
        cmf4_pkg::REG_GLYPHS: glyphs <= pwdata[cmf4_pkg::GLYPHS_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (reg_index)
      cmf4_pkg::REG_SEGS:   prdata = 32'(segs);
      cmf4_pkg::REG_GLYPHS: prdata = 32'(glyphs);
      default:              prdata = '0;
    endcase
  end

  assign cfg.segs   = segs;
  assign cfg.glyphs = glyphs;

endmodule

// File: hw/rtl/cmap_format4_glyph_lookup.sv
// cmap format 4 glyph lookup, top level.
// Request channel (req): each transfer carries a kind. Segment writes and glyph
// word writes store into the segment table or glyph array and produce no
// result; a write with an index past the table is dropped. A lookup transfer
// maps char_code to one result on the rsp channel (mapped, glyph_index).
// Configuration (segments_in_use at 0x0, glyph_words_in_use at 0x4) goes
// through the APB-style port. The user changes it only while the block is
// idle; the block itself does not enforce this.
// Flow: req.ready stays high for writes, so writes can follow back to back. A
// lookup scans segments_in_use entries, clamped to MAX_SEGMENTS: the segment
// table has one read port and is scanned one entry per cycle, then a short
// sequence on the shared adder forms the glyph array index, reads the array
// and adds the delta. Unmapped and direct-delta lookups skip the array steps,
// and an index past the array skips the read. req.ready is low while a lookup
// is in progress and returns as the result is loaded.
// Stalls: the result sits in an output register; a new request is taken while
// it waits, and a later lookup holds in its final step until the register is
// free. Reset clears the sequencer, the output valid flag and the two
// configuration registers; the memories are not cleared.
// Depends on cmf4_pkg, cmf4_channels, cmf4_ram, cmf4_alu and cmf4_cfg.
module cmap_format4_glyph_lookup #(
  parameter int MAX_SEGMENTS    = cmf4_pkg::MAX_SEGMENTS_DEF,
  parameter int MAX_GLYPH_WORDS = cmf4_pkg::MAX_GLYPH_WORDS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cmf4_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  cmf4_req_if.sink                    req,
  cmf4_rsp_if.source                  rsp
);

  localparam int SEG_AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int GLY_AW = (MAX_GLYPH_WORDS > 1) ? $clog2(MAX_GLYPH_WORDS) : 1;
  localparam int NW     = $clog2(MAX_SEGMENTS + 1);
  localparam int LW     = $clog2(MAX_GLYPH_WORDS + 1);
  localparam int AW     = cmf4_pkg::ALU_W;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SCAN  = 4'd1;
  localparam logic [3:0] S_NSUB  = 4'd2;
  localparam logic [3:0] S_BASE  = 4'd3;
  localparam logic [3:0] S_IDX   = 4'd4;
  localparam logic [3:0] S_LIM   = 4'd5;
  localparam logic [3:0] S_DELTA = 4'd6;
  localparam logic [3:0] S_OUT   = 4'd7;

  cmf4_pkg::cfg_t       cfg;
  cmf4_pkg::alu_req_t   alu_req;
  cmf4_pkg::alu_rsp_t   alu_rsp;
  cmf4_pkg::seg_entry_t seg_wr;
  cmf4_pkg::seg_entry_t seg_rd;

  logic [3:0]        state;
  logic [15:0]       code;
  logic [NW-1:0]     nseg;
  logic [LW-1:0]     limit;
  logic [NW-1:0]     issue_cnt;
  logic              pend;
  logic [SEG_AW-1:0] pend_idx;
  logic              hit;
  logic [SEG_AW-1:0] hit_idx;
  logic [15:0]       hit_delta;
  logic [15:0]       hit_offset;
  logic [15:0]       hit_cdiff;
  logic [15:0]       tmp;
  logic [16:0]       idx;
  logic [15:0]       glyph;
  logic              out_valid;
  logic              out_mapped;
  logic [15:0]       out_glyph;

  logic              accept;
  logic              seg_we;
  logic              gly_we;
  logic              seg_re;
  logic              gly_re;
  logic [15:0]       gword;
  logic              seg_match;
  logic              in_array;
  logic              out_load;

  cmf4_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;

  // Table writes
  assign seg_we = accept && (req.kind == cmf4_pkg::KIND_SEG) &&
                  (32'(req.entry_index) < MAX_SEGMENTS);
  assign gly_we = accept && (req.kind == cmf4_pkg::KIND_GLYPH) &&
                  (32'(req.entry_index) < MAX_GLYPH_WORDS);

  assign seg_wr.first  = req.range_first;
  assign seg_wr.last   = req.range_last;
  assign seg_wr.delta  = req.glyph_delta;
  assign seg_wr.offset = req.array_offset;

  assign seg_re = (state == S_SCAN) && (issue_cnt < nseg);

  cmf4_ram #(
    .WIDTH ($bits(cmf4_pkg::seg_entry_t)),
    .DEPTH (MAX_SEGMENTS),
    .AW    (SEG_AW)
  ) u_seg_ram (
    .clk   (clk),
    .we    (seg_we),
    .waddr (SEG_AW'(req.entry_index)),
    .wdata (seg_wr),
    .re    (seg_re),
    .raddr (SEG_AW'(issue_cnt)),
    .rdata (seg_rd)
  );

  cmf4_ram #(
    .WIDTH (16),
    .DEPTH (MAX_GLYPH_WORDS),
    .AW    (GLY_AW)
  ) u_glyph_ram (
    .clk   (clk),
    .we    (gly_we),
    .waddr (GLY_AW'(req.entry_index)),
    .wdata (req.glyph_word),
    .re    (gly_re),
    .raddr (GLY_AW'(idx)),
    .rdata (gword)
  );

  // Route the shared adder by sequencer step
  always_comb begin
    alu_req = '0;
    unique case (state)
      S_SCAN: begin
        alu_req.op0 = cmf4_pkg::ALU_SUB;
        alu_req.a0  = AW'(code);
        alu_req.b0  = AW'(seg_rd.first);
        alu_req.op1 = cmf4_pkg::ALU_SUB;
        alu_req.a1  = AW'(seg_rd.last);
        alu_req.b1  = AW'(code);
      end
      S_NSUB: begin
        if (hit_offset == 16'd0) begin
          alu_req.op0 = cmf4_pkg::ALU_ADD;
          alu_req.a0  = AW'(code);
          alu_req.b0  = AW'(hit_delta);
        end else begin
          alu_req.op0 = cmf4_pkg::ALU_SUB;
          alu_req.a0  = AW'(nseg);
          alu_req.b0  = AW'(hit_idx);
        end
      end
      S_BASE: begin
        alu_req.op0 = cmf4_pkg::ALU_SUB;
        alu_req.a0  = AW'(hit_offset[15:1]);
        alu_req.b0  = AW'(tmp);
      end
      S_IDX: begin
        alu_req.op0 = cmf4_pkg::ALU_ADD;
        alu_req.a0  = AW'(tmp);
        alu_req.b0  = AW'(hit_cdiff);
      end
      S_LIM: begin
        alu_req.op1 = cmf4_pkg::ALU_SUB;
        alu_req.a1  = AW'(idx);
        alu_req.b1  = AW'(limit);
      end
      S_DELTA: begin
        alu_req.op0 = cmf4_pkg::ALU_ADD;
        alu_req.a0  = AW'(gword);
        alu_req.b0  = AW'(hit_delta);
      end
      default: ;
    endcase
  end

  cmf4_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  assign seg_match = pend && !alu_rsp.r0[AW-1] && !alu_rsp.r1[AW-1];
  assign in_array  = alu_rsp.r1[AW-1];
  assign gly_re    = (state == S_LIM) && in_array;
  assign out_load  = (state == S_OUT) && (!out_valid || rsp.ready);

  // Lookup sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pend      <= 1'b0;
      hit       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // Raise the result on load, drop it once taken
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept && (req.kind == cmf4_pkg::KIND_LOOKUP)) begin
            code      <= req.char_code;
            nseg      <= (32'(cfg.segs) > MAX_SEGMENTS) ? NW'(MAX_SEGMENTS) : NW'(cfg.segs);
            limit     <= (32'(cfg.glyphs) > MAX_GLYPH_WORDS) ? LW'(MAX_GLYPH_WORDS)
                                                              : LW'(cfg.glyphs);
            issue_cnt <= '0;
            pend      <= 1'b0;
            hit       <= 1'b0;
            state     <= S_SCAN;
          end
        end
        S_SCAN: begin
          // One segment read issued and one compared per cycle
          if (seg_re) begin
            issue_cnt <= issue_cnt + NW'(1);
          end
          pend     <= seg_re;
          pend_idx <= SEG_AW'(issue_cnt);
          if (seg_match) begin
            hit        <= 1'b1;
            hit_idx    <= pend_idx;
            hit_delta  <= seg_rd.delta;
            hit_offset <= seg_rd.offset;
            hit_cdiff  <= alu_rsp.r0[15:0];
          end
          if (!seg_re && !pend) begin
            state <= S_NSUB;
          end
        end
        S_NSUB: begin
          if (!hit) begin
            glyph <= '0;
            state <= S_OUT;
          end else if (hit_offset == 16'd0) begin
            glyph <= alu_rsp.r0[15:0];
            state <= S_OUT;
          end else begin
            tmp   <= alu_rsp.r0[15:0];
            state <= S_BASE;
          end
        end
        S_BASE: begin
          tmp   <= alu_rsp.r0[15:0];
          state <= S_IDX;
        end
        S_IDX: begin
          idx   <= alu_rsp.r0[16:0];
          state <= S_LIM;
        end
        S_LIM: begin
          // Index past the loaded array maps to glyph zero
          if (in_array) begin
            state <= S_DELTA;
          end else begin
            glyph <= '0;
            state <= S_OUT;
          end
        end
        S_DELTA: begin
          glyph <= (gword == 16'd0) ? 16'd0 : alu_rsp.r0[15:0];
          state <= S_OUT;
        end
        S_OUT: begin
          // Hold until the output register is free
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_mapped <= hit;
      out_glyph  <= glyph;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.mapped      = out_mapped;
  assign rsp.glyph_index = out_glyph;

  // A lookup transfer blocks further requests on the next cycle
  a_lookup_blocks: assert property (@(posedge clk) disable iff (rst)
    (accept && (req.kind == cmf4_pkg::KIND_LOOKUP)) |=> !req.ready)
    else $error("request taken during a lookup");

  // Glyph word is consumed only right after its range check
  a_delta_after_lim: assert property (@(posedge clk) disable iff (rst)
    (state == S_DELTA) |-> $past(gly_re))
    else $error("glyph word used without an issued read");

  // Unmapped results carry glyph zero
  a_unmapped_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.mapped) |-> (rsp.glyph_index == 16'd0))
    else $error("unmapped result with nonzero glyph");

  // A finished lookup waits while the held result is stalled
  a_out_holds: assert property (@(posedge clk) disable iff (rst)
    ((state == S_OUT) && out_valid && !rsp.ready) |=> (state == S_OUT))
    else $error("result register overwritten while stalled");

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for cmap_format4_glyph_lookup: loads segment tables and glyph arrays,
// runs lookups under several register settings and checks every result against a predictor or a directed expectation.
// Depends on cmf4_pkg, cmf4_channels and the block's RTL.
module tb;

  localparam int          MAX_SEG       = cmf4_pkg::MAX_SEGMENTS_DEF;
  localparam int          MAX_WORDS     = cmf4_pkg::MAX_GLYPH_WORDS_DEF;
  localparam logic [1:0]  KIND_RESERVED = 2'd3;
  localparam int          ITEM_TARGET   = 1350;
  localparam int          HOLD_CYCLES   = 600;
  localparam int          SETTLE_CYCLES = 16;
  localparam int          END_WAIT      = 300;
  localparam int          CYCLE_LIMIT   = 1_500_000;

  typedef struct packed {
    logic [1:0]  kind;
    logic [11:0] entry_index;
    logic [15:0] range_first;
    logic [15:0] range_last;
    logic [15:0] glyph_delta;
    logic [15:0] array_offset;
    logic [15:0] glyph_word;
    logic [15:0] char_code;
  } cmap_item_t;

  localparam int ITEM_W = $bits(cmap_item_t);

  typedef struct packed {
    logic        mapped;
    logic [15:0] glyph;
  } glyph_result_t;

  typedef struct {
    bit            is_cfg;
    logic          cfg_reg;
    int unsigned   cfg_value;
    cmap_item_t    item;
    bit            typed;
    glyph_result_t want;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        psel, penable, pwrite;
  logic [cmf4_pkg::CFG_AW-1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;

  cmf4_req_if req_ch ();
  cmf4_rsp_if rsp_ch ();

  cmap_format4_glyph_lookup u_dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .req     (req_ch),
    .rsp     (rsp_ch)
  );

  always #1 clk = ~clk;

  // Predictor copy of the segment table, glyph array and registers
  logic [15:0] tbl_first  [MAX_SEG];
  logic [15:0] tbl_last   [MAX_SEG];
  logic [15:0] tbl_delta  [MAX_SEG];
  logic [15:0] tbl_offset [MAX_SEG];
  bit          seg_loaded [MAX_SEG];
  logic [15:0] glyph_words [MAX_WORDS];
  bit          word_loaded [MAX_WORDS];
  logic [cmf4_pkg::SEGS_W-1:0]   cur_segs;
  logic [cmf4_pkg::GLYPHS_W-1:0] cur_words;

  glyph_result_t expected_glyphs [$];
  dir_row_t      dir_rows [$];

  int  err_count = 0;
  int  n_items = 0, n_lookups = 0, n_checked = 0, n_mapped = 0, n_cfg = 0, n_phases = 0;
  bit  src_quiet = 1'b0;
  logic rsp_quiet = 1'b0;
  logic rsp_hold_go = 1'b0;
  logic hold_used = 1'b0;
  int   hold_left = 0;
  int   cycles = 0;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at cycle %0d: %s", cycles, msg);
    err_count++;
  endtask

  // Map a code the way the block does; flag any read of a never-written entry
  function automatic void map_code(input logic [15:0] code, output logic hit,
                                   output logic [15:0] glyph, output bit safe,
                                   output int need_word);
    int unsigned nseg, lim, base, idx, win, i;
    nseg = (cur_segs > MAX_SEG) ? MAX_SEG : cur_segs;
    lim  = (cur_words > MAX_WORDS) ? MAX_WORDS : cur_words;
    hit = 1'b0; glyph = 16'h0; safe = 1'b1; need_word = -1; win = 0;
    for (i = 0; i < nseg; i++) begin
      if (!seg_loaded[i]) safe = 1'b0;
      else if (tbl_first[i] <= code && code <= tbl_last[i]) begin
        hit = 1'b1;
        win = i;
      end
    end
    if (hit && safe) begin
      if (tbl_offset[win] == 16'h0) begin
        glyph = code + tbl_delta[win];
      end else begin
        base = ((tbl_offset[win] >> 1) - (nseg - win)) & 32'hFFFF;
        idx  = base + (code - tbl_first[win]);
        if (idx < lim) begin
          if (!word_loaded[idx]) begin
            safe = 1'b0;
            need_word = idx;
          end else begin
            glyph = glyph_words[idx];
            if (glyph != 16'h0) glyph = glyph + tbl_delta[win];
          end
        end
      end
    end
    if (!hit) glyph = 16'h0;
  endfunction

  // Update the predictor for one accepted transfer and queue its result
  task automatic apply_item(input cmap_item_t it, input bit typed, input glyph_result_t want);
    glyph_result_t got;
    bit            safe;
    int            need;
    case (it.kind)
      cmf4_pkg::KIND_SEG: begin
        if (it.entry_index < MAX_SEG) begin
          tbl_first[it.entry_index]  = it.range_first;
          tbl_last[it.entry_index]   = it.range_last;
          tbl_delta[it.entry_index]  = it.glyph_delta;
          tbl_offset[it.entry_index] = it.array_offset;
          seg_loaded[it.entry_index] = 1'b1;
          n_items++;
        end
      end
      cmf4_pkg::KIND_GLYPH: begin
        glyph_words[it.entry_index] = it.glyph_word;
        word_loaded[it.entry_index] = 1'b1;
        n_items++;
      end
      cmf4_pkg::KIND_LOOKUP: begin
        if (typed) begin
          expected_glyphs = {expected_glyphs, want};
        end else begin
          map_code(it.char_code, got.mapped, got.glyph, safe, need);
          expected_glyphs = {expected_glyphs, got};
        end
        n_items++;
        n_lookups++;
      end
      default: ;
    endcase
  endtask

  // Offer one item, idling at random cycle by cycle, and hold it until the transfer
  task automatic send_item(input cmap_item_t it, input bit typed, input glyph_result_t want);
    while (!src_quiet && $urandom_range(0, 99) < 31) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.kind         <= it.kind;
    req_ch.entry_index  <= it.entry_index;
    req_ch.range_first  <= it.range_first;
    req_ch.range_last   <= it.range_last;
    req_ch.glyph_delta  <= it.glyph_delta;
    req_ch.array_offset <= it.array_offset;
    req_ch.glyph_word   <= it.glyph_word;
    req_ch.char_code    <= it.char_code;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    apply_item(it, typed, want);
  endtask

  // Drop valid, wait for every expected result, then let the block settle
  task automatic wait_idle();
    req_ch.valid <= 1'b0;
    while (expected_glyphs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write a register through the APB port, then read it back
  task automatic write_register(input logic reg_sel, input int unsigned value);
    int unsigned width;
    logic [31:0] data, want;
    width = (reg_sel == cmf4_pkg::REG_SEGS) ? cmf4_pkg::SEGS_W : cmf4_pkg::GLYPHS_W;
    want  = value & ((32'd1 << width) - 1);
    data  = want;
    // junk above the field must be dropped
    if ($urandom_range(0, 2) == 0) data = data | ($urandom << width);
    wait_idle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (reg_sel == cmf4_pkg::REG_SEGS) cur_segs = want[cmf4_pkg::SEGS_W-1:0];
    else cur_words = want[cmf4_pkg::GLYPHS_W-1:0];
    n_cfg++;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== want)
      report_mismatch($sformatf("register %0d reads %h, wrote %h", reg_sel, prdata, want));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic cmap_item_t seg_item(input logic [11:0] idx, input logic [15:0] first,
                                          input logic [15:0] last, input logic [15:0] delta,
                                          input logic [15:0] off);
    cmap_item_t it;
    it = ITEM_W'({$urandom, $urandom, $urandom, $urandom});
    it.kind         = cmf4_pkg::KIND_SEG;
    it.entry_index  = idx;
    it.range_first  = first;
    it.range_last   = last;
    it.glyph_delta  = delta;
    it.array_offset = off;
    return it;
  endfunction

  function automatic cmap_item_t glyph_item(input logic [11:0] idx, input logic [15:0] word);
    cmap_item_t it;
    it = ITEM_W'({$urandom, $urandom, $urandom, $urandom});
    it.kind        = cmf4_pkg::KIND_GLYPH;
    it.entry_index = idx;
    it.glyph_word  = word;
    return it;
  endfunction

  function automatic cmap_item_t lookup_item(input logic [15:0] code);
    cmap_item_t it;
    it = ITEM_W'({$urandom, $urandom, $urandom, $urandom});
    it.kind      = cmf4_pkg::KIND_LOOKUP;
    it.char_code = code;
    return it;
  endfunction

  function automatic logic [15:0] random_word();
    return ($urandom_range(0, 3) == 0) ? 16'h0 : 16'($urandom);
  endfunction

  // Well-formed segment most of the time; offsets aim into the loaded array
  function automatic cmap_item_t random_segment(input int unsigned idx, input int unsigned nseg,
                                                input int unsigned lim);
    int unsigned first, last, span, off, sel;
    first = $urandom_range(0, 1) ? $urandom_range(0, 1023) : $urandom_range(0, 65535);
    span  = ($urandom_range(0, 99) < 70) ? $urandom_range(0, 15) : $urandom_range(0, 300);
    last  = (first + span > 65535) ? 65535 : first + span;
    // reversed bounds: the segment holds no code
    if ($urandom_range(0, 99) < 8 && first > 0) last = first - 1;
    sel = $urandom_range(0, 99);
    if (sel < 40) off = 0;
    else if (sel < 88 && lim > 0)
      off = 2 * ($urandom_range(0, lim - 1) + nseg - idx) + $urandom_range(0, 1);
    else off = $urandom_range(1, 65535);
    return seg_item(idx[11:0], first[15:0], last[15:0], 16'($urandom), off[15:0]);
  endfunction

  // One random item: mostly lookups that land in loaded segments
  task automatic send_random(input int unsigned nseg, input int unsigned lim);
    int unsigned pick, code, i, idx;
    logic        hit;
    logic [15:0] g;
    bit          safe;
    int          need;
    cmap_item_t  it;
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      code = $urandom_range(0, 65535);
      if (nseg > 0 && $urandom_range(0, 99) < 80) begin
        i = $urandom_range(0, nseg - 1);
        if (tbl_first[i] <= tbl_last[i]) begin
          case ($urandom_range(0, 4))
            0: code = tbl_first[i];
            1: code = tbl_last[i];
            default: code = $urandom_range(tbl_first[i], tbl_last[i]);
          endcase
        end
      end
      map_code(code[15:0], hit, g, safe, need);
      if (safe) it = lookup_item(code[15:0]);
      else if (need >= 0) it = glyph_item(need[11:0], random_word());
      else it = glyph_item(12'($urandom), random_word());
    end else if (pick < 74) begin
      idx = (nseg > 0 && $urandom_range(0, 99) < 85) ? $urandom_range(0, nseg - 1)
                                                     : $urandom_range(0, 4095);
      it = random_segment(idx, nseg, lim);
    end else if (pick < 90) begin
      idx = (lim > 0 && $urandom_range(0, 99) < 70) ? $urandom_range(0, lim - 1)
                                                    : $urandom_range(0, 4095);
      it = glyph_item(idx[11:0], random_word());
    end else if (pick < 95) begin
      it = lookup_item(16'($urandom));
      it.kind = KIND_RESERVED;
    end else begin
      // segment write past the table, dropped by the block
      it = random_segment($urandom_range(MAX_SEG, 4095), nseg, lim);
    end
    send_item(it, 1'b0, '0);
  endtask

  task automatic run_phase(input int p);
    int unsigned segs, words, nseg, lim, count, k, i;
    logic        quiet_rsp;
    count = 100;
    src_quiet = 1'b0;
    quiet_rsp = 1'b0;
    segs  = $urandom_range(1, 24);
    words = $urandom_range(1, 128);
    case (p)
      0: begin
        segs = $urandom_range(1, 8);
        words = $urandom_range(1, 64);
        src_quiet = 1'b1;
      end
      1: begin segs = 256; words = $urandom_range(16, 128); end
      2: words = 4096;
      3: begin segs = 511; words = 8191; end
      4: begin segs = 0; count = 40; end
      5: begin
        segs = $urandom_range(1, 16);
        src_quiet = 1'b1;
        quiet_rsp = 1'b1;
      end
      6: words = 0;
      default: if ($urandom_range(0, 9) == 0) segs = $urandom_range(250, 256);
    endcase
    rsp_quiet <= quiet_rsp;
    write_register(cmf4_pkg::REG_SEGS, segs);
    write_register(cmf4_pkg::REG_GLYPHS, words);
    nseg = (segs > MAX_SEG) ? MAX_SEG : segs;
    lim  = (words > MAX_WORDS) ? MAX_WORDS : words;
    // load every segment that will be scanned, and small arrays whole
    for (i = 0; i < nseg; i++)
      if (!seg_loaded[i]) send_item(random_segment(i, nseg, lim), 1'b0, '0);
    if (lim <= 128)
      for (i = 0; i < lim; i++)
        if (!word_loaded[i]) send_item(glyph_item(i[11:0], random_word()), 1'b0, '0);
    for (k = 0; k < count; k++) begin
      if (p == 0 && k == 15) rsp_hold_go <= 1'b1;
      if (p == 5 && k == count / 2) wait_idle();
      send_random(nseg, lim);
    end
    n_phases++;
  endtask

  function automatic void add_row(input cmap_item_t it, input bit typed, input logic m,
                                  input logic [15:0] g);
    dir_row_t row;
    row.is_cfg = 1'b0;
    row.cfg_reg = 1'b0;
    row.cfg_value = 0;
    row.item = it;
    row.typed = typed;
    row.want.mapped = m;
    row.want.glyph = g;
    dir_rows = {dir_rows, row};
  endfunction

  function automatic void add_cfg(input logic reg_sel, input int unsigned value);
    dir_row_t row;
    row.is_cfg = 1'b1;
    row.cfg_reg = reg_sel;
    row.cfg_value = value;
    row.item = '0;
    row.typed = 1'b0;
    row.want = '0;
    dir_rows = {dir_rows, row};
  endfunction

  // Receiver: random idling, one long hold-off, quiet stretch on request
  always @(posedge clk) begin
    if (rsp_hold_go && !hold_used) begin
      hold_used <= 1'b1;
      hold_left <= HOLD_CYCLES;
      rsp_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      rsp_ch.ready <= 1'b0;
    end else if (rsp_quiet) begin
      rsp_ch.ready <= 1'b1;
    end else begin
      rsp_ch.ready <= ($urandom_range(0, 99) >= 31);
    end
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk) begin : check_results
    glyph_result_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (expected_glyphs.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected: mapped=%0b glyph=%h",
                                  rsp_ch.mapped, rsp_ch.glyph_index));
      end else begin
        want = expected_glyphs.pop_front();
        if (rsp_ch.mapped !== want.mapped)
          report_mismatch($sformatf("mapped %0b, expected %0b", rsp_ch.mapped, want.mapped));
        if (rsp_ch.glyph_index !== want.glyph)
          report_mismatch($sformatf("glyph_index %h, expected %h",
                                    rsp_ch.glyph_index, want.glyph));
        n_checked++;
        if (want.mapped) n_mapped++;
      end
    end
  end

  // Abort a hung run
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin
    int p;
    rst                 <= 1'b1;
    psel                <= 1'b0;
    penable             <= 1'b0;
    pwrite              <= 1'b0;
    paddr               <= '0;
    pwdata              <= '0;
    req_ch.valid        <= 1'b0;
    req_ch.kind         <= '0;
    req_ch.entry_index  <= '0;
    req_ch.range_first  <= '0;
    req_ch.range_last   <= '0;
    req_ch.glyph_delta  <= '0;
    req_ch.array_offset <= '0;
    req_ch.glyph_word   <= '0;
    req_ch.char_code    <= '0;
    cur_segs  = '0;
    cur_words = '0;

    // Directed rows: empty table, extremes, overlap, zero word, past-array index
    add_row(lookup_item(16'h0000), 1'b1, 1'b0, 16'h0000);
    add_row(lookup_item(16'hFFFF), 1'b1, 1'b0, 16'h0000);
    add_row({KIND_RESERVED, 12'hFFF, {6{16'hFFFF}}}, 1'b0, 1'b0, 16'h0);
    add_row(seg_item(12'd0, 16'h0041, 16'h005A, 16'hFFE3, 16'h0000), 1'b0, 1'b0, 16'h0);
    add_row(seg_item(12'd1, 16'h1000, 16'h1003, 16'h0005, 16'h0007), 1'b0, 1'b0, 16'h0);
    add_row(seg_item(12'd2, 16'hFFFF, 16'hFFFF, 16'h8000, 16'h0000), 1'b0, 1'b0, 16'h0);
    add_row(seg_item(12'd3, 16'h0041, 16'h0041, 16'h0100, 16'h0000), 1'b0, 1'b0, 16'h0);
    add_row(seg_item(12'hFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF), 1'b0, 1'b0, 16'h0);
    add_row(seg_item(12'd256, 16'h0000, 16'hFFFF, 16'h0001, 16'h0000), 1'b0, 1'b0, 16'h0);
    add_row(glyph_item(12'd0, 16'h0010), 1'b0, 1'b0, 16'h0);
    add_row(glyph_item(12'd1, 16'h0000), 1'b0, 1'b0, 16'h0);
    add_row(glyph_item(12'd2, 16'hFFFF), 1'b0, 1'b0, 16'h0);
    add_row(glyph_item(12'd3, 16'h1234), 1'b0, 1'b0, 16'h0);
    add_row(glyph_item(12'hFFF, 16'hABCD), 1'b0, 1'b0, 16'h0);
    add_cfg(cmf4_pkg::REG_SEGS, 4);
    add_cfg(cmf4_pkg::REG_GLYPHS, 4);
    add_row(lookup_item(16'h0041), 1'b1, 1'b1, 16'h0141);
    add_row(lookup_item(16'h0042), 1'b0, 1'b0, 16'h0);
    add_row(lookup_item(16'h0040), 1'b1, 1'b0, 16'h0000);
    add_row(lookup_item(16'h1000), 1'b0, 1'b0, 16'h0);
    add_row(lookup_item(16'h1001), 1'b1, 1'b1, 16'h0000);
    add_row(lookup_item(16'h1002), 1'b0, 1'b0, 16'h0);
    add_row(lookup_item(16'hFFFF), 1'b0, 1'b0, 16'h0);
    add_cfg(cmf4_pkg::REG_GLYPHS, 3);
    add_row(lookup_item(16'h1003), 1'b1, 1'b1, 16'h0000);
    add_cfg(cmf4_pkg::REG_GLYPHS, 4096);
    add_row(lookup_item(16'h1003), 1'b0, 1'b0, 16'h0);
    add_row(seg_item(12'd0, 16'h0050, 16'h004F, 16'h7FFF, 16'h0000), 1'b0, 1'b0, 16'h0);
    add_row(lookup_item(16'h0045), 1'b1, 1'b0, 16'h0000);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Walk the directed rows
    foreach (dir_rows[k]) begin
      if (dir_rows[k].is_cfg) write_register(dir_rows[k].cfg_reg, dir_rows[k].cfg_value);
      else send_item(dir_rows[k].item, dir_rows[k].typed, dir_rows[k].want);
    end

    // Random phases under changing register settings
    p = 0;
    while (p < 7 || n_items < ITEM_TARGET) begin
      run_phase(p);
      p++;
    end
    src_quiet = 1'b0;
    rsp_quiet <= 1'b0;

    wait_idle();
    repeat (END_WAIT) @(posedge clk);
    $display("covered %0d items in %0d random phases: %0d lookups checked, %0d mapped",
             n_items, n_phases, n_checked, n_mapped);
    $display("register writes: %0d, segment counts 0 to 511, glyph array sizes 0 to 8191",
             n_cfg);
    if (err_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
